@@ design/lodd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lodd_pkg
// Shared types, sizes and helper functions of the lock-order deadlock
// detector.
// ----------------------------------------------------------------------------
package lodd_pkg;

   localparam int MAX_LOCKS   = 16;
   localparam int STACK_DEPTH = 16;

   // Fixed field widths of the request and response items.
   localparam int CMD_W    = 1;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 3;
   localparam int HELD_W   = 5;

   // Derived internal widths.
   localparam int LOCK_W  = $clog2(MAX_LOCKS);
   localparam int DEPTH_W = $clog2(MAX_LOCKS + 1);
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int HS_AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DEADLOCK   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ID_W-1:0]  lock_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HELD_W-1:0]   held_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOP,
      S_EDGE,
      S_ROOT,
      S_NODE,
      S_POP,
      S_DONE
   } lodd_state_type;

   // Folds a raw lock id into the range of lock numbers by repeated subtraction.
   function automatic logic [LOCK_W-1:0] fold_id(input logic [ID_W-1:0] raw);
      logic [7:0] v;
      v = 8'(raw);
      for (int i = 0; i < 8; i++) begin
         if (v >= 8'(MAX_LOCKS)) begin
            v = v - 8'(MAX_LOCKS);
         end
      end
      return LOCK_W'(v);
   endfunction

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [LOCK_W-1:0] lowest_set(input logic [MAX_LOCKS-1:0] m);
      logic [LOCK_W-1:0] r;
      r = '0;
      for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = LOCK_W'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/lodd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lodd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lodd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/lock_order_deadlock_detector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector_top
// Tracks held locks on a stack, records lock-order edges in an adjacency
// matrix and runs a depth-first cycle search whenever a new edge appears.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    lodd_pkg::req_type
//   rsp_      out         rsp_valid/rsp_ready    lodd_pkg::rsp_type
//
// A release or an acquire that adds no new edge does not run the search. An
// acquire that adds a new edge runs the search, which makes one graph memory
// read per root, per discovered node and per finished node plus one stack
// read per backtrack.
// Graph rows carry valid bits cleared by reset, so no clearing pass is needed.
// A new request is taken while the previous response waits in rsp_data.
// ----------------------------------------------------------------------------
module lock_order_deadlock_detector_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lodd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lodd_pkg::rsp_type      rsp_data
);

   localparam int LW = lodd_pkg::LOCK_W;
   localparam int ML = lodd_pkg::MAX_LOCKS;
   localparam int DW = lodd_pkg::DEPTH_W;
   localparam int SW = lodd_pkg::SP_W;
   localparam int HW = lodd_pkg::HS_AW;

   lodd_pkg::lodd_state_type state_ff, state_in;

   logic [SW-1:0]                    sp_ff, sp_in;
   logic [lodd_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [LW-1:0]                    id_ff, id_in;
   logic [LW-1:0]                    prev_ff, prev_in;
   logic [ML-1:0]                    visited_ff, visited_in;
   logic [ML-1:0]                    finished_ff, finished_in;
   logic [DW-1:0]                    depth_ff, depth_in;
   logic [DW-1:0]                    root_ff, root_in;
   logic [LW-1:0]                    node_ff, node_in;
   logic [lodd_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   lodd_pkg::rsp_type                rsp_ff, rsp_in;
   logic [ML-1:0]                    row_valid_ff, row_valid_in;
   logic [LW-1:0]                    graph_raddr_ff;

   // Memory ports.
   logic          held_we;
   logic [HW-1:0] held_waddr, held_raddr;
   logic [LW-1:0] held_rdata;
   logic          graph_we;
   logic [LW-1:0] graph_waddr, graph_raddr;
   logic [ML-1:0] graph_wdata, graph_rdata;
   logic          sstk_we;
   logic [LW-1:0] sstk_waddr, sstk_raddr, sstk_wdata, sstk_rdata;

   logic [ML-1:0] row;
   logic [ML-1:0] fresh;
   logic [LW-1:0] next_node;

   lodd_ram #(.WIDTH(LW), .DEPTH(lodd_pkg::STACK_DEPTH)) u_held_stack (
      .clock   (clock),
      .wr_en   (held_we),
      .wr_addr (held_waddr),
      .wr_data (id_ff),
      .rd_addr (held_raddr),
      .rd_data (held_rdata)
   );

   lodd_ram #(.WIDTH(ML), .DEPTH(ML)) u_order_graph (
      .clock   (clock),
      .wr_en   (graph_we),
      .wr_addr (graph_waddr),
      .wr_data (graph_wdata),
      .rd_addr (graph_raddr),
      .rd_data (graph_rdata)
   );

   lodd_ram #(.WIDTH(LW), .DEPTH(ML)) u_search_stack (
      .clock   (clock),
      .wr_en   (sstk_we),
      .wr_addr (sstk_waddr),
      .wr_data (sstk_wdata),
      .rd_addr (sstk_raddr),
      .rd_data (sstk_rdata)
   );

   // A row that was never written reads as no edges.
   assign row       = row_valid_ff[graph_raddr_ff] ? graph_rdata : '0;
   assign fresh     = row & ~visited_ff;
   assign next_node = lodd_pkg::lowest_set(fresh);

   assign req_ready  = (state_ff == lodd_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign held_raddr = HW'(sp_ff - SW'(1));

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      prev_in      = prev_ff;
      visited_in   = visited_ff;
      finished_in  = finished_ff;
      depth_in     = depth_ff;
      root_in      = root_ff;
      node_in      = node_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      row_valid_in = row_valid_ff;
      held_we      = 1'b0;
      held_waddr   = HW'(sp_ff);
      graph_we     = 1'b0;
      graph_waddr  = prev_ff;
      graph_wdata  = row | (ML'(1) << id_ff);
      graph_raddr  = node_ff;
      sstk_we      = 1'b0;
      sstk_waddr   = LW'(depth_ff);
      sstk_wdata   = next_node;
      sstk_raddr   = LW'(depth_ff - DW'(2));

      unique case (state_ff)
         lodd_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               id_in    = lodd_pkg::fold_id(req_data.lock_id);
               state_in = lodd_pkg::S_TOP;
            end
         end

         lodd_pkg::S_TOP: begin
            status_in = lodd_pkg::STATUS_OK;
            state_in  = lodd_pkg::S_DONE;
            if (cmd_ff == lodd_pkg::CMD_RELEASE) begin
               if (sp_ff == '0) begin
                  status_in = lodd_pkg::STATUS_EMPTY;
               end else if (held_rdata != id_ff) begin
                  status_in = lodd_pkg::STATUS_MISMATCH;
               end else begin
                  sp_in = sp_ff - SW'(1);
               end
            end else if (sp_ff >= SW'(lodd_pkg::STACK_DEPTH)) begin
               status_in = lodd_pkg::STATUS_STACK_FULL;
            end else if (sp_ff == '0) begin
               held_we = 1'b1;
               sp_in   = sp_ff + SW'(1);
            end else begin
               prev_in     = held_rdata;
               graph_raddr = held_rdata;
               state_in    = lodd_pkg::S_EDGE;
            end
         end

         lodd_pkg::S_EDGE: begin
            held_we  = 1'b1;
            sp_in    = sp_ff + SW'(1);
            state_in = lodd_pkg::S_DONE;
            if (prev_ff != id_ff && !row[id_ff]) begin
               graph_we              = 1'b1;
               row_valid_in[prev_ff] = 1'b1;
               visited_in            = '0;
               finished_in           = '0;
               root_in               = '0;
               state_in              = lodd_pkg::S_ROOT;
            end
         end

         lodd_pkg::S_ROOT: begin
            graph_raddr = LW'(root_ff);
            if (root_ff == DW'(ML)) begin
               state_in = lodd_pkg::S_DONE;
            end else if (visited_ff[LW'(root_ff)]) begin
               root_in = root_ff + DW'(1);
            end else begin
               visited_in[LW'(root_ff)] = 1'b1;
               sstk_we    = 1'b1;
               sstk_waddr = '0;
               sstk_wdata = LW'(root_ff);
               depth_in   = DW'(1);
               node_in    = LW'(root_ff);
               state_in   = lodd_pkg::S_NODE;
            end
         end

         lodd_pkg::S_NODE: begin
            // An edge into a node on the current path closes a cycle.
            if ((row & visited_ff & ~finished_ff) != '0) begin
               status_in = lodd_pkg::STATUS_DEADLOCK;
               state_in  = lodd_pkg::S_DONE;
            end else if (fresh != '0) begin
               visited_in[next_node] = 1'b1;
               if (depth_ff < DW'(ML)) begin
                  sstk_we     = 1'b1;
                  depth_in    = depth_ff + DW'(1);
                  node_in     = next_node;
                  graph_raddr = next_node;
               end else begin
                  graph_raddr = node_ff;
               end
            end else begin
               finished_in[node_ff] = 1'b1;
               depth_in             = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  root_in  = root_ff + DW'(1);
                  state_in = lodd_pkg::S_ROOT;
               end else begin
                  state_in = lodd_pkg::S_POP;
               end
            end
         end

         lodd_pkg::S_POP: begin
            node_in     = sstk_rdata;
            graph_raddr = sstk_rdata;
            state_in    = lodd_pkg::S_NODE;
         end

         lodd_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.held_count = lodd_pkg::HELD_W'(sp_ff);
               state_in          = lodd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = lodd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lodd_pkg::S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         visited_ff   <= '0;
         finished_ff  <= '0;
         depth_ff     <= '0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         visited_ff   <= visited_in;
         finished_ff  <= finished_in;
         depth_ff     <= depth_in;
         root_ff      <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      prev_ff        <= prev_in;
      node_ff        <= node_in;
      status_ff      <= status_in;
      rsp_ff         <= rsp_in;
      graph_raddr_ff <= graph_raddr;
   end

`ifndef SYNTHESIS
   a_sp_bound : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(lodd_pkg::STACK_DEPTH))
      else $error("held stack pointer beyond stack depth");

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(ML))
      else $error("search depth beyond lock count");

   a_finished_visited : assert property (@(posedge clock) disable iff (reset)
      (finished_ff & ~visited_ff) == '0)
      else $error("finished node that was never visited");

   a_accept_to_top : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == lodd_pkg::S_TOP)
      else $error("accepted request did not start processing");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending response was overwritten");
`endif

endmodule
`default_nettype wire
